// File: hw/rtl/rpm_pkg.sv
// Shared types, codes and widths for the reference picture marking block.
// No dependencies.
package rpm_pkg;

   localparam int SLOTS_DEF = 16;

   localparam int CMD_W     = 3;
   localparam int FN_W      = 16;
   localparam int VIEW_W    = 10;
   localparam int LTI_W     = 4;
   localparam int LIM_W     = 5;
   localparam int KEY_W     = 5;
   localparam int CFG_W     = 5;
   localparam int MAXFN_W   = FN_W + 1;
   localparam int PIC_W     = FN_W + 2;
   localparam int OUT_IDX_W = 4;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [CMD_W-1:0] CMD_STORE      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DROP_SHORT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DROP_LONG  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TO_LONG    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LIMIT_LONG = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR_ALL  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_MARK_CUR   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_NONE       = 3'd7;

   localparam logic REG_FN_BITS   = 1'b0;
   localparam logic REG_ACT_SLOTS = 1'b1;

   localparam logic [CFG_W-1:0] FN_BITS_RST   = 5'd4;
   localparam logic [CFG_W-1:0] ACT_SLOTS_RST = 5'd16;
   localparam logic [CFG_W-1:0] FN_BITS_MIN   = 5'd4;
   localparam logic [CFG_W-1:0] FN_BITS_MAX   = 5'd16;

   typedef struct packed {
      logic              is_short;
      logic [FN_W-1:0]   number;
      logic [VIEW_W-1:0] view;
   } slot_entry_type;

   typedef struct packed {
      logic [CFG_W-1:0] fn_bits;
      logic [CFG_W-1:0] act_slots;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [FN_W-1:0]   cur_frame_num;
      logic [VIEW_W-1:0] cur_view;
      logic              is_idr;
      logic              idr_long_term;
      logic [FN_W-1:0]   diff_pic_minus1;
      logic [LTI_W-1:0]  long_term_pic;
      logic [LTI_W-1:0]  long_term_slot_idx;
      logic [LIM_W-1:0]  long_term_limit;
   } item_type;

endpackage

// File: hw/rtl/rpm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/rpm_ctrl.sv
// Marking sequencer: scans the slot memory one entry per cycle, keeps the
// per-slot used bits and builds the allocation result. Uses rpm_pkg, rpm_ram.
module rpm_ctrl
   import rpm_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 start,
   input  item_type             item,
   output logic                 busy,
   output logic                 rsp_strobe,
   output logic                 rsp_found,
   output logic [OUT_IDX_W-1:0] rsp_index
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int ENT_W = $bits(slot_entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC
   } state_type;

   state_type state_ff, state_in;
   logic [SLOTS-1:0] used_ff, used_in;
   logic mmco_ff, mmco_in;
   logic pend_ff, pend_in;
   logic [LTI_W-1:0] pend_idx_ff, pend_idx_in;
   logic strobe_ff, strobe_in;
   logic found_ff, found_in;
   logic [OUT_IDX_W-1:0] index_ff, index_in;

   logic [CMD_W-1:0] op_ff, op_in;
   logic [FN_W-1:0] cur_ff, cur_in;
   logic [VIEW_W-1:0] view_ff, view_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic signed [PIC_W-1:0] pnx_ff, pnx_in;
   logic st_long_ff, st_long_in;
   logic [LTI_W-1:0] st_idx_ff, st_idx_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic have_ff, have_in;
   logic signed [PIC_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0] old_ff, old_in;
   logic conv_ff, conv_in;

   logic [CFG_W-1:0] fb;
   logic [MAXFN_W-1:0] maxfn;
   logic [CNT_W-1:0] n;
   logic [SLOTS-1:0] act_mask, free;
   logic [IDX_W-1:0] free_idx;
   logic full;

   logic we, re;
   logic [IDX_W-1:0] waddr, raddr;
   slot_entry_type wdata, e;
   logic [ENT_W-1:0] rdata;

   logic u, short_hit, long_eq, long_ge, win_cand, scan_done;
   logic signed [PIC_W-1:0] pic;

   rpm_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign e = slot_entry_type'(rdata);

   always_comb begin
      if (cfg.fn_bits < FN_BITS_MIN) begin
         fb = FN_BITS_MIN;
      end else if (cfg.fn_bits > FN_BITS_MAX) begin
         fb = FN_BITS_MAX;
      end else begin
         fb = cfg.fn_bits;
      end
      maxfn = MAXFN_W'(1) << fb;
      if (int'(cfg.act_slots) > SLOTS) begin
         n = CNT_W'(SLOTS);
      end else begin
         n = CNT_W'(cfg.act_slots);
      end
      for (int s = 0; s < SLOTS; s++) begin
         act_mask[s] = CNT_W'(s) < n;
      end
      free = ~used_ff & act_mask;
      free_idx = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (free[s]) begin
            free_idx = IDX_W'(s);
         end
      end
      full = (n != '0) && (&(used_ff | ~act_mask));
   end

   always_comb begin
      u = used_ff[chk_idx_ff];
      if ({2'b00, e.number} > {2'b00, cur_ff}) begin
         pic = signed'({2'b00, e.number}) - signed'({1'b0, maxfn});
      end else begin
         pic = signed'({2'b00, e.number});
      end
      short_hit = chk_vld_ff && u && e.is_short && (pic == pnx_ff);
      long_eq   = chk_vld_ff && u && !e.is_short && (e.number == FN_W'(key_ff));
      long_ge   = chk_vld_ff && u && !e.is_short && (e.number >= FN_W'(key_ff));
      win_cand  = chk_vld_ff && u && e.is_short && (e.view == view_ff) &&
                  (!have_ff || (pic < best_ff));
      scan_done = (iss_ff == n) && !chk_vld_ff;
   end

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      mmco_in     = mmco_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      strobe_in   = 1'b0;
      found_in    = found_ff;
      index_in    = index_ff;
      op_in       = op_ff;
      cur_in      = cur_ff;
      view_in     = view_ff;
      key_in      = key_ff;
      pnx_in      = pnx_ff;
      st_long_in  = st_long_ff;
      st_idx_in   = st_idx_ff;
      iss_in      = iss_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      have_in     = have_ff;
      best_in     = best_ff;
      old_in      = old_ff;
      conv_in     = conv_ff;
      we          = 1'b0;
      waddr       = chk_idx_ff;
      wdata       = '0;
      re          = 1'b0;
      raddr       = iss_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = item.cmd;
               cur_in     = item.cur_frame_num & FN_W'(maxfn - MAXFN_W'(1));
               view_in    = item.cur_view;
               pnx_in     = signed'({2'b00, cur_in}) -
                            signed'({2'b00, item.diff_pic_minus1}) - PIC_W'(1);
               iss_in     = '0;
               have_in    = 1'b0;
               best_in    = '0;
               old_in     = '0;
               conv_in    = 1'b0;
               st_long_in = item.is_idr ? item.idr_long_term : pend_ff;
               st_idx_in  = item.is_idr ? '0 : pend_idx_ff;
               priority case (item.cmd)
                  CMD_DROP_LONG:  key_in = {1'b0, item.long_term_pic};
                  CMD_LIMIT_LONG: key_in = item.long_term_limit;
                  default:        key_in = {1'b0, item.long_term_slot_idx};
               endcase
               unique case (item.cmd)
                  CMD_STORE: begin
                     if (item.is_idr) begin
                        used_in  = used_ff & ~act_mask;
                        state_in = ST_ALLOC;
                     end else if (!mmco_ff && full) begin
                        state_in = ST_SCAN;
                     end else begin
                        state_in = ST_ALLOC;
                     end
                  end
                  CMD_CLEAR_ALL: begin
                     mmco_in = 1'b1;
                     used_in = used_ff & ~act_mask;
                  end
                  CMD_MARK_CUR: begin
                     mmco_in     = 1'b1;
                     pend_in     = 1'b1;
                     pend_idx_in = item.long_term_slot_idx;
                     state_in    = ST_SCAN;
                  end
                  CMD_DROP_SHORT, CMD_DROP_LONG, CMD_TO_LONG, CMD_LIMIT_LONG: begin
                     mmco_in  = 1'b1;
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (iss_ff != n) begin
               re         = 1'b1;
               iss_in     = iss_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[IDX_W-1:0];
            end
            unique case (op_ff)
               CMD_DROP_SHORT: begin
                  if (short_hit) used_in[chk_idx_ff] = 1'b0;
               end
               CMD_DROP_LONG, CMD_MARK_CUR: begin
                  if (long_eq) used_in[chk_idx_ff] = 1'b0;
               end
               CMD_LIMIT_LONG: begin
                  if (long_ge) used_in[chk_idx_ff] = 1'b0;
               end
               CMD_TO_LONG: begin
                  if (long_eq) begin
                     used_in[chk_idx_ff] = 1'b0;
                  end else if (short_hit && !conv_ff) begin
                     we             = 1'b1;
                     wdata.is_short = 1'b0;
                     wdata.number   = FN_W'(key_ff);
                     wdata.view     = e.view;
                     conv_in        = 1'b1;
                  end
               end
               CMD_STORE: begin
                  if (win_cand) begin
                     have_in = 1'b1;
                     best_in = pic;
                     old_in  = chk_idx_ff;
                  end
               end
               default: begin
               end
            endcase
            if (scan_done) begin
               if (op_ff == CMD_STORE) begin
                  if (have_ff) used_in[old_ff] = 1'b0;
                  state_in = ST_ALLOC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_ALLOC: begin
            strobe_in   = 1'b1;
            found_in    = |free;
            index_in    = (|free) ? OUT_IDX_W'(free_idx) : '0;
            if (|free) begin
               we             = 1'b1;
               waddr          = free_idx;
               wdata.is_short = !st_long_ff;
               wdata.number   = st_long_ff ? FN_W'(st_idx_ff) : cur_ff;
               wdata.view     = view_ff;
               used_in[free_idx] = 1'b1;
            end
            mmco_in     = 1'b0;
            pend_in     = 1'b0;
            pend_idx_in = '0;
            state_in    = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         used_ff     <= '0;
         mmco_ff     <= 1'b0;
         pend_ff     <= 1'b0;
         pend_idx_ff <= '0;
         strobe_ff   <= 1'b0;
         found_ff    <= 1'b0;
         index_ff    <= '0;
         chk_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         mmco_ff     <= mmco_in;
         pend_ff     <= pend_in;
         pend_idx_ff <= pend_idx_in;
         strobe_ff   <= strobe_in;
         found_ff    <= found_in;
         index_ff    <= index_in;
         chk_vld_ff  <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      cur_ff     <= cur_in;
      view_ff    <= view_in;
      key_ff     <= key_in;
      pnx_ff     <= pnx_in;
      st_long_ff <= st_long_in;
      st_idx_ff  <= st_idx_in;
      iss_ff     <= iss_in;
      chk_idx_ff <= chk_idx_in;
      have_ff    <= have_in;
      best_ff    <= best_in;
      old_ff     <= old_in;
      conv_ff    <= conv_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_found  = found_ff;
   assign rsp_index  = index_ff;

endmodule

// File: hw/rtl/reference_picture_marking.sv
// Top level of the reference picture marking block: register port and sequencer.
// Uses rpm_pkg and rpm_ctrl.
//
// Items are taken when start is high and busy is low. Ops 1, 2, 3, 4 and 6 keep
// the block busy while the slot memory is read through its single port, one
// active slot per cycle. Op 5 and the unused code do not make the block busy.
// A store is busy in the allocation state alone, or scans the slots first when
// the sliding window has to scan for the oldest frame; its result strobes for
// one cycle in the cycle after busy falls and cannot be held off, so it must be
// taken then. Registers: frame_num_bits at 0x0, active_slots at 0x4.
module reference_picture_marking
   import rpm_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [FN_W-1:0]      req_cur_frame_num,
   input  logic [VIEW_W-1:0]    req_cur_view,
   input  logic                 req_is_idr,
   input  logic                 req_idr_long_term,
   input  logic [FN_W-1:0]      req_diff_pic_minus1,
   input  logic [LTI_W-1:0]     req_long_term_pic,
   input  logic [LTI_W-1:0]     req_long_term_slot_idx,
   input  logic [LIM_W-1:0]     req_long_term_limit,
   output logic                 rsp_strobe,
   output logic                 rsp_slot_found,
   output logic [OUT_IDX_W-1:0] rsp_slot_index,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [DATA_W-1:0]    pwdata,
   output logic [DATA_W-1:0]    prdata,
   output logic                 pready
);

   logic [CFG_W-1:0] fn_bits_ff, fn_bits_in;
   logic [CFG_W-1:0] act_ff, act_in;
   logic wr;
   cfg_type cfg;
   item_type item;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_comb begin
      fn_bits_in = fn_bits_ff;
      act_in     = act_ff;
      if (wr) begin
         unique case (paddr[2])
            REG_FN_BITS:   fn_bits_in = pwdata[CFG_W-1:0];
            REG_ACT_SLOTS: act_in     = pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
      unique case (paddr[2])
         REG_ACT_SLOTS: prdata = DATA_W'(act_ff);
         default:       prdata = DATA_W'(fn_bits_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fn_bits_ff <= FN_BITS_RST;
         act_ff     <= ACT_SLOTS_RST;
      end else begin
         fn_bits_ff <= fn_bits_in;
         act_ff     <= act_in;
      end
   end

   assign cfg.fn_bits   = fn_bits_ff;
   assign cfg.act_slots = act_ff;

   assign item.cmd                = req_cmd;
   assign item.cur_frame_num      = req_cur_frame_num;
   assign item.cur_view           = req_cur_view;
   assign item.is_idr             = req_is_idr;
   assign item.idr_long_term      = req_idr_long_term;
   assign item.diff_pic_minus1    = req_diff_pic_minus1;
   assign item.long_term_pic      = req_long_term_pic;
   assign item.long_term_slot_idx = req_long_term_slot_idx;
   assign item.long_term_limit    = req_long_term_limit;

   rpm_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .start      (start),
      .item       (item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_found  (rsp_slot_found),
      .rsp_index  (rsp_slot_index)
   );

`ifndef SYNTHESIS
   a_store_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_STORE) |=> busy)
      else $error("store transfer did not enter a busy phase");

   a_one_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_no_slot_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_slot_found |-> rsp_slot_index == '0)
      else $error("slot index not zero on a failed allocation");

   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a preceding busy cycle");
`endif

endmodule

// File: sim/testbench.sv
// Testbench for reference_picture_marking: picture stores and marking operations over several
// register settings, each slot report checked against a cycle-free model of the slot table.
// Depends on rpm_pkg and the reference_picture_marking RTL.
module testbench;
   import rpm_pkg::*;

   typedef struct {
      logic                 found;
      logic [OUT_IDX_W-1:0] index;
   } slot_report_type;

   class slot_table_tracker;
      bit              used       [SLOTS_DEF];
      bit              is_short   [SLOTS_DEF];
      int unsigned     number     [SLOTS_DEF];
      int unsigned     view_of    [SLOTS_DEF];
      bit              ops_since_store;
      bit              want_long;
      int unsigned     want_long_idx;
      int unsigned     fn_bits_reg;
      int unsigned     act_slots_reg;
      slot_report_type reports [$];
      int unsigned     checked;
      int unsigned     stores;
      int unsigned     empty_stores;
      int unsigned     misses;

      function new();
         fn_bits_reg   = 32'(FN_BITS_RST);
         act_slots_reg = 32'(ACT_SLOTS_RST);
      endfunction

      function void write_reg(logic idx, int unsigned value);
         if (idx == REG_FN_BITS) begin
            fn_bits_reg = value & 31;
         end else begin
            act_slots_reg = value & 31;
         end
      endfunction

      function int unsigned live();
         return (act_slots_reg > SLOTS_DEF) ? SLOTS_DEF : act_slots_reg;
      endfunction

      function int unsigned frame_mod();
         int unsigned b;
         b = fn_bits_reg;
         if (b < FN_BITS_MIN) begin
            b = 32'(FN_BITS_MIN);
         end else if (b > FN_BITS_MAX) begin
            b = 32'(FN_BITS_MAX);
         end
         return 1 << b;
      endfunction

      function int pic_of(int s, int unsigned cur, int unsigned maxfn);
         int p;
         p = int'(number[s]);
         if (number[s] > cur) p -= int'(maxfn);
         return p;
      endfunction

      function void drop_long(int unsigned idx, bit at_or_above);
         for (int s = 0; s < live(); s++) begin
            if (used[s] && !is_short[s] &&
                (at_or_above ? number[s] >= idx : number[s] == idx))
               used[s] = 1'b0;
         end
      endfunction

      // picture number difference minus one that hits some short-term frame, or -1
      function int diff_to_short(logic [FN_W-1:0] frame);
         int unsigned maxfn, cur;
         int          p;
         int          cand [$];
         maxfn = frame_mod();
         cur   = frame & (maxfn - 1);
         for (int s = 0; s < live(); s++) begin
            if (used[s] && is_short[s]) begin
               p = pic_of(s, cur, maxfn);
               if (p < int'(cur) && int'(cur) - p - 1 <= 65535)
                  cand.push_back(int'(cur) - p - 1);
            end
         end
         if (cand.size() == 0) return -1;
         return cand[$urandom_range(cand.size() - 1, 0)];
      endfunction

      function void take_item(item_type it);
         int unsigned     maxfn, cur, n, cnt, old, lidx;
         int              pnx, best, p, s;
         bit              have, as_long;
         slot_report_type r;
         maxfn = frame_mod();
         cur   = it.cur_frame_num & (maxfn - 1);
         n     = live();
         pnx   = int'(cur) - int'(it.diff_pic_minus1) - 1;
         if (it.cmd == CMD_NONE) return;
         if (it.cmd != CMD_STORE) begin
            ops_since_store = 1'b1;
            case (it.cmd)
               CMD_DROP_SHORT: begin
                  for (s = 0; s < n; s++)
                     if (used[s] && is_short[s] && pic_of(s, cur, maxfn) == pnx) used[s] = 1'b0;
               end
               CMD_DROP_LONG: drop_long(32'(it.long_term_pic), 1'b0);
               CMD_TO_LONG: begin
                  drop_long(32'(it.long_term_slot_idx), 1'b0);
                  for (s = 0; s < n; s++) begin
                     if (used[s] && is_short[s] && pic_of(s, cur, maxfn) == pnx) begin
                        is_short[s] = 1'b0;
                        number[s]   = 32'(it.long_term_slot_idx);
                        break;
                     end
                  end
               end
               CMD_LIMIT_LONG: drop_long(32'(it.long_term_limit), 1'b1);
               CMD_CLEAR_ALL: begin
                  for (s = 0; s < n; s++) used[s] = 1'b0;
               end
               default: begin
                  drop_long(32'(it.long_term_slot_idx), 1'b0);
                  want_long     = 1'b1;
                  want_long_idx = 32'(it.long_term_slot_idx);
               end
            endcase
            return;
         end
         if (it.is_idr) begin
            for (s = 0; s < n; s++) used[s] = 1'b0;
            as_long = it.idr_long_term;
            lidx    = 0;
         end else begin
            if (!ops_since_store && n > 0) begin
               cnt = 0;
               for (s = 0; s < n; s++) if (used[s]) cnt++;
               if (cnt >= n) begin
                  // sliding window: oldest short-term frame of this view
                  have = 1'b0;
                  best = 0;
                  old  = 0;
                  for (s = 0; s < n; s++) begin
                     if (used[s] && is_short[s] && view_of[s] == it.cur_view) begin
                        p = pic_of(s, cur, maxfn);
                        if (!have || p < best) begin
                           have = 1'b1;
                           best = p;
                           old  = s;
                        end
                     end
                  end
                  if (have) used[old] = 1'b0;
               end
            end
            as_long = want_long;
            lidx    = want_long_idx;
         end
         r.found = 1'b0;
         r.index = '0;
         for (s = 0; s < n; s++) begin
            if (!used[s]) begin
               used[s]     = 1'b1;
               is_short[s] = !as_long;
               number[s]   = as_long ? lidx : cur;
               view_of[s]  = 32'(it.cur_view);
               r.found     = 1'b1;
               r.index     = s[OUT_IDX_W-1:0];
               break;
            end
         end
         ops_since_store = 1'b0;
         want_long       = 1'b0;
         want_long_idx   = 0;
         stores++;
         if (!r.found) empty_stores++;
         reports.push_back(r);
      endfunction

      function void check_slot(logic found, logic [OUT_IDX_W-1:0] index);
         slot_report_type e;
         checked++;
         if (reports.size() == 0) begin
            misses++;
            if (misses <= 10)
               $display("unexpected slot report: found=%0d index=%0d", found, index);
            return;
         end
         e = reports.pop_front();
         if (found !== e.found || index !== e.index) begin
            misses++;
            if (misses <= 10)
               $display("slot report mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
                        e.found, e.index, found, index);
         end
      endfunction
   endclass

   logic                 clock   = 1'b0;
   logic                 reset   = 1'b1;
   logic                 start   = 1'b0;
   item_type             req     = '0;
   logic                 psel    = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite  = 1'b0;
   logic [ADDR_W-1:0]    paddr   = '0;
   logic [DATA_W-1:0]    pwdata  = '0;
   logic                 busy;
   logic                 rsp_strobe;
   logic                 rsp_slot_found;
   logic [OUT_IDX_W-1:0] rsp_slot_index;
   logic [DATA_W-1:0]    prdata;
   logic                 pready;

   slot_table_tracker tracker;
   int unsigned       gap_cap;
   int unsigned       transfers;
   int unsigned       settings;
   int unsigned       fnb_plan [10] = '{16, 4, 8, 0, 31, 5, 12, 16, 6, 4};
   int unsigned       act_plan [10] = '{16, 3, 1, 31, 8, 0, 2, 16, 5, 16};

   reference_picture_marking #(.SLOTS(SLOTS_DEF)) uut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_cmd                (req.cmd),
      .req_cur_frame_num      (req.cur_frame_num),
      .req_cur_view           (req.cur_view),
      .req_is_idr             (req.is_idr),
      .req_idr_long_term      (req.idr_long_term),
      .req_diff_pic_minus1    (req.diff_pic_minus1),
      .req_long_term_pic      (req.long_term_pic),
      .req_long_term_slot_idx (req.long_term_slot_idx),
      .req_long_term_limit    (req.long_term_limit),
      .rsp_strobe             (rsp_strobe),
      .rsp_slot_found         (rsp_slot_found),
      .rsp_slot_index         (rsp_slot_index),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) tracker.check_slot(rsp_slot_found, rsp_slot_index);
   end

   task automatic csr_write(logic idx, int unsigned value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tracker.write_reg(idx, value);
   endtask

   // one transfer on the request side, after a random idle gap
   task automatic issue(item_type it);
      int unsigned gap;
      gap = $urandom_range(gap_cap, 0);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req   <= it;
      do @(posedge clock); while (busy);
      tracker.take_item(it);
      transfers++;
   endtask

   // drain: all reports in, then enough cycles for a trailing operation scan
   task automatic settle();
      start <= 1'b0;
      while (tracker.reports.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic item_type mk(logic [CMD_W-1:0] cmd, int unsigned fn, int unsigned view,
                                   int unsigned idr, int unsigned idr_lt, int unsigned diff,
                                   int unsigned ltpic, int unsigned ltidx, int unsigned lim);
      item_type it;
      it.cmd                = cmd;
      it.cur_frame_num      = FN_W'(fn);
      it.cur_view           = VIEW_W'(view);
      it.is_idr             = 1'(idr);
      it.idr_long_term      = 1'(idr_lt);
      it.diff_pic_minus1    = FN_W'(diff);
      it.long_term_pic      = LTI_W'(ltpic);
      it.long_term_slot_idx = LTI_W'(ltidx);
      it.long_term_limit    = LIM_W'(lim);
      return it;
   endfunction

   function automatic item_type noise();
      return mk(CMD_W'($urandom_range(7, 0)), $urandom, $urandom_range(1023, 0),
                $urandom_range(1, 0), $urandom_range(1, 0), $urandom, $urandom_range(15, 0),
                $urandom_range(15, 0), $urandom_range(16, 0));
   endfunction

   function automatic int unsigned lt_pick();
      return ($urandom_range(3, 0) != 0) ? $urandom_range(3, 0) : $urandom_range(15, 0);
   endfunction

   // three slots, four frame bits
   task automatic directed();
      issue(mk(CMD_STORE, 0, 0, 1, 0, 0, 0, 0, 0));
      issue(mk(CMD_STORE, 1, 0, 0, 0, 0, 0, 0, 0));
      issue(mk(CMD_STORE, 2, 1, 0, 0, 0, 0, 0, 0));
      issue(mk(CMD_STORE, 3, 0, 0, 0, 0, 0, 0, 0));
      issue(mk(CMD_STORE, 4, 5, 0, 0, 0, 0, 0, 0));
      issue(mk(CMD_DROP_SHORT, 5, 0, 0, 0, 3, 0, 0, 0));
      issue(mk(CMD_TO_LONG, 5, 0, 0, 0, 1, 0, 2, 0));
      issue(mk(CMD_MARK_CUR, 5, 0, 0, 0, 0, 0, 2, 0));
      issue(mk(CMD_STORE, 5, 0, 0, 0, 0, 0, 0, 0));
      issue(mk(CMD_DROP_LONG, 6, 0, 0, 0, 0, 2, 0, 0));
      issue(mk(CMD_LIMIT_LONG, 6, 0, 0, 0, 0, 0, 0, 0));
      issue(mk(CMD_CLEAR_ALL, 6, 0, 0, 0, 0, 0, 0, 0));
      issue(mk(CMD_NONE, 16'hFFFF, 1023, 1, 1, 16'hFFFF, 15, 15, 16));
      issue(mk(CMD_STORE, 16'hFFFF, 1023, 0, 1, 16'hFFFF, 15, 15, 16));
      issue(mk(CMD_MARK_CUR, 0, 0, 0, 0, 0, 0, 15, 0));
      issue(mk(CMD_STORE, 0, 0, 1, 1, 0, 0, 0, 0));
      issue(mk(CMD_STORE, 3, 0, 0, 0, 0, 0, 0, 0));
      issue(mk(CMD_STORE, 3, 1, 0, 0, 0, 0, 0, 0));
      issue(mk(CMD_TO_LONG, 4, 0, 0, 0, 0, 0, 0, 0));
      issue(mk(CMD_DROP_SHORT, 4, 0, 0, 0, 16'hFFFF, 0, 0, 0));
      issue(mk(CMD_LIMIT_LONG, 4, 0, 0, 0, 0, 0, 0, 16));
      issue(mk(CMD_STORE, 14, 0, 0, 0, 0, 0, 0, 0));
      issue(mk(CMD_DROP_SHORT, 2, 0, 0, 0, 3, 0, 0, 0));
      issue(mk(CMD_DROP_LONG, 2, 0, 0, 0, 0, 15, 0, 0));
      issue(mk(CMD_STORE, 2, 1, 0, 0, 0, 15, 15, 16));
   endtask

   // pictures: a few marking operations, then the store; some noise mixed in
   task automatic run_phase(int unsigned items);
      item_type    it;
      int unsigned done, nops, fn, view, r;
      int          d;
      done = 0;
      fn   = $urandom_range(65535, 0);
      while (done < items) begin
         if ($urandom_range(15, 0) == 0) gap_cap = $urandom_range(1, 0) ? 0 : 11;
         fn   = (($urandom_range(9, 0) == 0) ? $urandom : fn + 1) & 16'hFFFF;
         view = ($urandom_range(9, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(1, 0);
         if ($urandom_range(19, 0) == 0) begin
            issue(noise());
            done++;
         end else begin
            nops = ($urandom_range(2, 0) == 0) ? $urandom_range(3, 1) : 0;
            repeat (nops) begin
               it = noise();
               it.cur_frame_num = FN_W'(fn);
               it.cur_view      = VIEW_W'(view);
               r = $urandom_range(15, 0);
               if (r < 5) it.cmd = CMD_DROP_SHORT;
               else if (r < 7) it.cmd = CMD_DROP_LONG;
               else if (r < 11) it.cmd = CMD_TO_LONG;
               else if (r < 12) it.cmd = CMD_LIMIT_LONG;
               else if (r < 13) it.cmd = CMD_CLEAR_ALL;
               else it.cmd = CMD_MARK_CUR;
               d = tracker.diff_to_short(FN_W'(fn));
               if (d >= 0 && $urandom_range(3, 0) != 0) it.diff_pic_minus1 = FN_W'(d);
               else if ($urandom_range(1, 0)) it.diff_pic_minus1 = FN_W'($urandom_range(7, 0));
               it.long_term_pic      = LTI_W'(lt_pick());
               it.long_term_slot_idx = LTI_W'(lt_pick());
               if ($urandom_range(1, 0)) it.long_term_limit = LIM_W'($urandom_range(4, 0));
               issue(it);
               done++;
            end
            it = noise();
            it.cmd           = CMD_STORE;
            it.cur_frame_num = FN_W'(fn);
            it.cur_view      = VIEW_W'(view);
            it.is_idr        = ($urandom_range(24, 0) == 0);
            issue(it);
            done++;
         end
      end
   endtask

   initial begin
      tracker   = new();
      gap_cap   = 11;
      transfers = 0;
      settings  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      csr_write(REG_FN_BITS, 4);
      csr_write(REG_ACT_SLOTS, 3);
      settings++;
      directed();
      settle();
      for (int k = 0; k < 10; k++) begin
         csr_write(REG_FN_BITS, fnb_plan[k]);
         csr_write(REG_ACT_SLOTS, act_plan[k]);
         settings++;
         run_phase(80);
         settle();
      end
      if (tracker.reports.size() != 0) begin
         tracker.misses++;
         $display("%0d slot reports never arrived", tracker.reports.size());
      end
      $display("covered %0d transfers, %0d stores (%0d without a free slot), %0d register settings",
               transfers, tracker.stores, tracker.empty_stores, settings);
      $display("%0d slot reports checked, %0d failures", tracker.checked, tracker.misses);
      if (tracker.misses == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: reference_picture_marking.f
hw/rtl/rpm_pkg.sv
hw/rtl/rpm_ram.sv
hw/rtl/rpm_ctrl.sv
hw/rtl/reference_picture_marking.sv
sim/testbench.sv
